### design/bmf_pkg.sv
package bmf_pkg;

    // fixed port widths
    localparam int PORT_BITS = 16;
    localparam int CFG_BITS  = 11;

    // parameter defaults
    localparam int MAX_SIDE_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    // image side limits
    localparam int SIDE_RESET = 32;
    localparam int MIN_SIDE   = 2;

    localparam int NUM_CH = 3;

    // neighborhood sizes: corner uses a shift, edge and inner a reciprocal
    localparam int CORNER_SHIFT = 2;
    localparam int EDGE_DIV     = 6;
    localparam int INNER_DIV    = 9;

    typedef enum logic [1:0] {
        CNT_4 = 2'd0,
        CNT_6 = 2'd1,
        CNT_9 = 2'd2
    } cnt_t;

endpackage

### design/box_mean_3x3_filter.sv
// Channel  Handshake                Payload
// -------  -----------------------  ----------------------------------------
// cfg      cfg_wr_en                cfg_wr_data (image side, clamped)
// in       in_valid / in_ready      red_in, green_in, blue_in, drain
// out      out_valid / out_ready    red_out, green_out, blue_out, frame_end
//
// One item per clock unless out_ready stalls. out_valid rises when the item
// completing a window reaches stage 4; in item count, results lag by side+1.
// Both line stores share one memory word per column, read when the item is
// taken and written back as the item leaves the first stage. Reset clears
// positions and valids; the line memory is not cleared. Stages move on when
// the one ahead is free, so bubbles close up while out_ready is low.
module box_mean_3x3_filter #(
    parameter int MAX_SIDE     = bmf_pkg::MAX_SIDE_DEF,
    parameter int CHANNEL_BITS = bmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bmf_pkg::CFG_BITS-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bmf_pkg::PORT_BITS-1:0] red_in,
    input  logic [bmf_pkg::PORT_BITS-1:0] green_in,
    input  logic [bmf_pkg::PORT_BITS-1:0] blue_in,
    input  logic                          drain,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmf_pkg::PORT_BITS-1:0] red_out,
    output logic [bmf_pkg::PORT_BITS-1:0] green_out,
    output logic [bmf_pkg::PORT_BITS-1:0] blue_out,
    output logic                          frame_end
);

    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int COL_W    = $clog2(MAX_SIDE);
    localparam int ROW_W    = $clog2(MAX_SIDE + 2);
    localparam int CB       = CHANNEL_BITS;
    localparam int NCH      = bmf_pkg::NUM_CH;
    localparam int COLSUM_W = CB + 2;
    localparam int SUM_W    = CB + 4;
    localparam int PIX_W    = NCH * CB;
    localparam int LINE_W   = 2 * PIX_W;
    localparam int PB       = bmf_pkg::PORT_BITS;
    localparam int SIDE_RST = (bmf_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                               : bmf_pkg::SIDE_RESET;

    typedef struct packed {
        logic          has_out;
        logic          last;
        logic          top_ok;
        logic          bot_ok;
        logic          left;
        logic          right;
        bmf_pkg::cnt_t cnt;
    } item_ctrl_t;

    // ---------------- position state ----------------
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [31:0]       cfg_ext;

    logic [ROW_W-1:0]  side_row;
    logic [SIDE_W-1:0] col_inc;
    logic col0, col1, row1, row2, row_n, row_n1;
    logic flushing, ignore, in_fire, take, wrap;
    logic top_row, bot_row, row_edge, col_edge;
    item_ctrl_t        ctrl0;
    logic [PIX_W-1:0]  pix0;

    assign cfg_ext = 32'(cfg_wr_data);

    always_comb
    begin
        if (cfg_ext < 32'(bmf_pkg::MIN_SIDE))
        begin
            side_next = SIDE_W'(bmf_pkg::MIN_SIDE);
        end
        else if (cfg_ext > 32'(MAX_SIDE))
        begin
            side_next = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_next = SIDE_W'(cfg_ext);
        end
    end

    assign side_row = ROW_W'(side_reg);
    assign col0     = (col_reg == '0);
    assign col1     = (col_reg == COL_W'(1));
    assign row1     = (row_reg == ROW_W'(1));
    assign row2     = (row_reg == ROW_W'(2));
    assign row_n    = (row_reg == side_row);
    assign row_n1   = (row_reg == side_row + ROW_W'(1));
    assign flushing = (row_reg >= side_row);
    assign ignore   = drain && !flushing;
    assign in_fire  = in_valid && in_ready;
    assign take     = in_fire && !ignore;
    assign col_inc  = SIDE_W'(col_reg) + SIDE_W'(1);
    assign wrap     = (col_inc >= side_reg);

    // output position is (row-1, col-1), or (row-2, side-1) at column zero
    assign top_row  = col0 ? row2 : row1;
    assign bot_row  = col0 ? row_n1 : row_n;
    assign row_edge = top_row || bot_row;
    assign col_edge = col0 || col1;

    always_comb
    begin
        ctrl0.has_out = (row_reg >= ROW_W'(2)) || (row1 && !col0);
        ctrl0.last    = col0 && row_n1;
        // entering column is centered on row-1
        ctrl0.top_ok  = !row1;
        ctrl0.bot_ok  = !row_n;
        ctrl0.left    = col1;
        ctrl0.right   = col0;
        if (row_edge && col_edge)
        begin
            ctrl0.cnt = bmf_pkg::CNT_4;
        end
        else if (row_edge || col_edge)
        begin
            ctrl0.cnt = bmf_pkg::CNT_6;
        end
        else
        begin
            ctrl0.cnt = bmf_pkg::CNT_9;
        end
    end

    assign pix0 = flushing ? '0 : {blue_in[CB-1:0], green_in[CB-1:0], red_in[CB-1:0]};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (ctrl0.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(SIDE_RST);
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                side_reg <= side_next;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy2, rdy3, rdy4, mv1, mv2, mv3;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = !v1_reg || rdy2;
    assign mv1      = v1_reg && rdy2;
    assign mv2      = v2_reg && rdy3;
    assign mv3      = v3_reg && rdy4;

    item_ctrl_t        ctrl1_reg, ctrl2_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [COL_W-1:0]  addr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v1_reg <= take;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg && ctrl1_reg.has_out;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic [LINE_W-1:0] line_rd;
    logic [LINE_W-1:0] line_wr;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctrl1_reg <= ctrl0;
            pix1_reg  <= pix0;
            addr1_reg <= col_reg;
        end
    end

    // word layout: upper row above middle row; write shifts middle up
    assign line_wr = {line_rd[PIX_W-1:0], pix1_reg};

    bmf_line_mem #(
        .DEPTH  (MAX_SIDE),
        .WIDTH  (LINE_W),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (line_rd),
        .wr_en   (mv1),
        .wr_addr (addr1_reg),
        .wr_data (line_wr)
    );

    // ---------------- stage 2: column sums into window ----------------
    logic [COLSUM_W-1:0] colsum [NCH];
    logic [COLSUM_W-1:0] win_reg [3][NCH];

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            colsum[ch] = (ctrl1_reg.top_ok ? COLSUM_W'(line_rd[PIX_W + ch*CB +: CB]) : '0)
                       + COLSUM_W'(line_rd[ch*CB +: CB])
                       + (ctrl1_reg.bot_ok ? COLSUM_W'(pix1_reg[ch*CB +: CB]) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv1)
        begin
            ctrl2_reg <= ctrl1_reg;
            for (int ch = 0; ch < NCH; ch++)
            begin
                win_reg[0][ch] <= win_reg[1][ch];
                win_reg[1][ch] <= win_reg[2][ch];
                win_reg[2][ch] <= colsum[ch];
            end
        end
    end

    // ---------------- stage 3: window sum ----------------
    logic [SUM_W-1:0] sum_next [NCH];
    logic [SUM_W-1:0] sum3_reg [NCH];
    bmf_pkg::cnt_t    cnt3_reg;
    logic             last3_reg;

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            sum_next[ch] = (ctrl2_reg.left ? '0 : SUM_W'(win_reg[0][ch]))
                         + SUM_W'(win_reg[1][ch])
                         + (ctrl2_reg.right ? '0 : SUM_W'(win_reg[2][ch]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            sum3_reg  <= sum_next;
            cnt3_reg  <= ctrl2_reg.cnt;
            last3_reg <= ctrl2_reg.last;
        end
    end

    // ---------------- stage 4: divide and output register ----------------
    logic [CB-1:0] quot [NCH];
    logic [PB-1:0] red_reg, green_reg, blue_reg;
    logic          frame_end_reg;

    for (genvar g = 0; g < NCH; g++)
    begin : g_div
        bmf_div #(
            .SUM_W (SUM_W),
            .Q_W   (CB)
        ) u_div (
            .sum  (sum3_reg[g]),
            .cnt  (cnt3_reg),
            .quot (quot[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (mv3)
        begin
            red_reg       <= PB'(quot[0]);
            green_reg     <= PB'(quot[1]);
            blue_reg      <= PB'(quot[2]);
            frame_end_reg <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign frame_end = frame_end_reg;

`ifndef ASSERT_OFF
    a_col_in_side: assert property (@(posedge clk) disable iff (!rst_n)
        SIDE_W'(col_reg) < side_reg)
        else $error("column position beyond image side");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= side_row + ROW_W'(1))
        else $error("row position beyond flush range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && col0 && row_n1)
        |=> (row_reg == '0) && (col_reg == '0))
        else $error("positions not cleared after last item of frame");

    a_drain_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && drain && (row_reg < side_row) && !cfg_wr_en)
        |=> ($stable(row_reg) && $stable(col_reg)))
        else $error("early drain item moved the position");
`endif

endmodule

### design/bmf_line_mem.sv
module bmf_line_mem #(
    parameter int DEPTH  = bmf_pkg::MAX_SIDE_DEF,
    parameter int WIDTH  = 2 * bmf_pkg::NUM_CH * bmf_pkg::CHANNEL_BITS_DEF,
    parameter int ADDR_W = $clog2(bmf_pkg::MAX_SIDE_DEF)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // same-address write in this cycle wins
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/bmf_div.sv
module bmf_div #(
    parameter int SUM_W = bmf_pkg::CHANNEL_BITS_DEF + 4,
    parameter int Q_W   = bmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic               [SUM_W-1:0] sum,
    input  bmf_pkg::cnt_t                  cnt,
    output logic               [Q_W-1:0]   quot
);

    // floor(x/d) == (x*M) >> K for x < 2**SUM_W with M = ceil(2**K/d)
    localparam int K6     = SUM_W + 3;
    localparam int K9     = SUM_W + 4;
    localparam int M6     = ((1 << K6) + bmf_pkg::EDGE_DIV - 1) / bmf_pkg::EDGE_DIV;
    localparam int M9     = ((1 << K9) + bmf_pkg::INNER_DIV - 1) / bmf_pkg::INNER_DIV;
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;

    logic [MUL_W-1:0]  recip;
    logic [PROD_W-1:0] prod;

    assign recip = (cnt == bmf_pkg::CNT_9) ? MUL_W'(M9) : MUL_W'(M6);
    assign prod  = PROD_W'(sum) * PROD_W'(recip);

    always_comb
    begin
        case (cnt)
            bmf_pkg::CNT_4: quot = Q_W'(sum >> bmf_pkg::CORNER_SHIFT);
            bmf_pkg::CNT_6: quot = Q_W'(prod >> K6);
            bmf_pkg::CNT_9: quot = Q_W'(prod >> K9);
            default:        quot = '0;
        endcase
    end

endmodule
